### design/sum_difference_histogram_macros.svh
// Assertion macros for the sum and difference histogram block.
`ifndef SUM_DIFFERENCE_HISTOGRAM_MACROS_SVH
`define SUM_DIFFERENCE_HISTOGRAM_MACROS_SVH
`ifndef SYNTH
`define SDH_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define SDH_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SDH_ASSERT(label, clk, rst_n, prop)
`define SDH_ASSERT_RST(label, clk, prop)
`endif
`endif

### design/sdh_pkg.sv
// Shared types and constants for the sum and difference histogram block.
package sdh_pkg;
  localparam int unsigned BinCount = 511;
  localparam int unsigned BinW     = 9;
  localparam int unsigned CntW     = 21;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [1:0] KIND_PIXEL = 2'd0;
  localparam logic [1:0] KIND_READ  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] REG_DIST   = 2'd0;
  localparam logic [1:0] REG_DIR    = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic [1:0] DIR_0   = 2'd0;
  localparam logic [1:0] DIR_45  = 2'd1;
  localparam logic [1:0] DIR_90  = 2'd2;
  localparam logic [1:0] DIR_135 = 2'd3;

  // bin update request toward the histogram unit
  typedef struct packed {
    logic            bump;
    logic [BinW-1:0] sum_bin;
    logic [BinW-1:0] diff_bin;
  } bin_req_t;
endpackage

### design/sdh_bins.sv
// Sum and difference bin memories with read-modify-write, read port and clear sweep.
`include "sum_difference_histogram_macros.svh"
module sdh_bins (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sdh_pkg::bin_req_t              req_i,
  input  logic                           rd_i,
  input  logic [sdh_pkg::BinW-1:0]       rd_bin_i,
  input  logic                           clr_i,
  output logic                           busy_o,
  output logic [sdh_pkg::CntW-1:0]       sum_o,
  output logic [sdh_pkg::CntW-1:0]       diff_o
);
  import sdh_pkg::*;

  logic [CntW-1:0] sum_mem [BinCount];
  logic [CntW-1:0] diff_mem [BinCount];

  logic [BinW-1:0] clr_q, clr_d;
  logic            clring_q, clring_d;
  logic            upd_q;
  logic [BinW-1:0] sbin_q, dbin_q;
  logic [CntW-1:0] srd_q, drd_q;
  logic [CntW-1:0] sval, dval, snew, dnew;
  logic            sfwd_q, dfwd_q;
  logic [CntW-1:0] sfv_q, dfv_q;
  logic [BinW-1:0] sra, dra;

  assign busy_o = clring_q;
  assign sra = req_i.bump ? req_i.sum_bin  : rd_bin_i;
  assign dra = req_i.bump ? req_i.diff_bin : rd_bin_i;

  // forwarded value when the bin written last cycle is read again
  assign sval = sfwd_q ? sfv_q : srd_q;
  assign dval = dfwd_q ? dfv_q : drd_q;
  assign snew = (sval == CntMax) ? sval : sval + 1'b1;
  assign dnew = (dval == CntMax) ? dval : dval + 1'b1;
  assign sum_o  = sval;
  assign diff_o = dval;

  always_comb begin
    clr_d = clr_q;
    clring_d = clring_q;
    if (clr_i) begin
      clring_d = 1'b1;
      clr_d = '0;
    end else if (clring_q) begin
      clr_d = clr_q + 1'b1;
      if (clr_q == BinW'(BinCount - 1)) clring_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      clring_q <= 1'b1;
      upd_q <= 1'b0;
      sfwd_q <= 1'b0;
      dfwd_q <= 1'b0;
    end else begin
      clr_q <= clr_d;
      clring_q <= clring_d;
      upd_q <= req_i.bump && !clring_q && !clr_i;
      sfwd_q <= upd_q && (sbin_q == sra);
      dfwd_q <= upd_q && (dbin_q == dra);
    end
  end

  always_ff @(posedge clk_i) begin
    sfv_q <= snew;
    dfv_q <= dnew;
    if (req_i.bump || rd_i) begin
      sbin_q <= sra;
      dbin_q <= dra;
    end
    if (sra < BinW'(BinCount)) srd_q <= sum_mem[sra];
    else srd_q <= '0;
    if (dra < BinW'(BinCount)) drd_q <= diff_mem[dra];
    else drd_q <= '0;
    if (clring_q) begin
      sum_mem[clr_q]  <= '0;
      diff_mem[clr_q] <= '0;
    end else if (upd_q) begin
      sum_mem[sbin_q]  <= snew;
      diff_mem[dbin_q] <= dnew;
    end
  end

  `SDH_ASSERT(a_no_upd_clr, clk_i, rst_ni, clring_q |-> !upd_q)
  `SDH_ASSERT(a_clr_end, clk_i, rst_ni, $fell(clring_q) |-> $past(clr_q) == BinW'(BinCount - 1))
  `SDH_ASSERT_RST(a_rst_clr, clk_i, !rst_ni |=> clring_q)
endmodule

### design/sum_difference_histogram.sv
// Sum and difference histogram: top level with pixel history and control.
// A read item's result goes from the bin memory read register into the output register.
// Items are not taken back to back: a pixel holds the input for its bin
// read-modify-write (with forwarding), a read until its result can go.
// Reset and every clear item start a clear sweep over all 511 bins of the bin
// memories; no input is taken then. The pixel history memory is not cleared.
`include "sum_difference_histogram_macros.svh"
module sum_difference_histogram #(
  parameter int unsigned MAX_WIDTH    = 1024,
  parameter int unsigned MAX_HEIGHT   = 1024,
  parameter int unsigned MAX_DISTANCE = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] pixel, [16:8] bin_index, rest zero
  input  logic [1:0]  s_axis_tuser,  // [1:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,  // bin_number, sum_count, diff_count, pair_total
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import sdh_pkg::*;

  localparam int unsigned HistDepth = MAX_DISTANCE * MAX_WIDTH + MAX_DISTANCE;
  localparam int unsigned HpW = $clog2(HistDepth);
  localparam int unsigned PosW = 12;

  // configuration registers
  logic [4:0]  dist_q;
  logic [1:0]  dir_q;
  logic [10:0] width_q, height_q;

  // frame position and pair counter
  logic [PosW-1:0] col_q, row_q;
  logic [HpW-1:0]  hp_q;
  logic [CntW-1:0] pairs_q;

  // one stage after history read
  logic           p1_q;
  logic           pair1_q, first1_q;
  logic [7:0]     pix1_q;
  logic [7:0]     hist_rd_q;

  logic [7:0] hist_mem [HistDepth];

  // read result path
  logic           rd1_q;
  logic [BinW-1:0] rbin1_q;
  logic           outv_q;
  logic [71:0]    outd_q;
  logic           busy;

  logic in_acc;
  logic [1:0] kind;
  logic [7:0] pix;
  logic [BinW-1:0] bin;
  assign kind = s_axis_tuser;
  assign pix  = s_axis_tdata[7:0];
  assign bin  = s_axis_tdata[16:8];

  // hold input during clear, while a pixel bump is in flight, and while a read is in flight or waiting
  assign s_axis_tready = !busy && !rd1_q && !(outv_q && !m_axis_tready) && !p1_q;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  // pairing geometry
  logic geom_ok, dist_ok, pair_now, first_now;
  logic [PosW-1:0] wl, hl, dl;
  logic [HpW+1:0] back;
  always_comb begin
    wl = PosW'(width_q);
    hl = PosW'(height_q);
    dl = PosW'(dist_q);
    geom_ok = width_q >= 11'd2 && 32'(width_q) <= MAX_WIDTH &&
              height_q >= 11'd2 && 32'(height_q) <= MAX_HEIGHT;
    dist_ok = dist_q >= 5'd1 && 32'(dist_q) <= MAX_DISTANCE && dl < wl && dl < hl;
    pair_now = 1'b0;
    first_now = 1'b1;
    back = '0;
    unique case (dir_q)
      DIR_0: begin
        pair_now = col_q >= dl;
        first_now = 1'b0;
        back = (HpW+2)'(dist_q);
      end
      DIR_45: begin
        pair_now = row_q >= dl && col_q < wl - dl;
        back = (HpW+2)'(dist_q) * (HpW+2)'(width_q) - (HpW+2)'(dist_q);
      end
      DIR_90: begin
        pair_now = row_q >= dl;
        back = (HpW+2)'(dist_q) * (HpW+2)'(width_q);
      end
      default: begin
        pair_now = row_q >= dl && col_q >= dl;
        back = (HpW+2)'(dist_q) * (HpW+2)'(width_q) + (HpW+2)'(dist_q);
      end
    endcase
    pair_now = pair_now && dist_ok;
  end

  logic [HpW+1:0] ra_wide;
  logic [HpW-1:0] ra;
  assign ra_wide = (HpW+2)'(hp_q) + (HpW+2)'(HistDepth) - back;
  assign ra = (ra_wide >= (HpW+2)'(HistDepth)) ? HpW'(ra_wide - (HpW+2)'(HistDepth))
                                                : HpW'(ra_wide);

  logic take_pix;
  assign take_pix = in_acc && kind == KIND_PIXEL && geom_ok;

  always_ff @(posedge clk_i) begin
    if (take_pix) begin
      hist_mem[hp_q] <= pix;
      hist_rd_q <= hist_mem[ra];
    end
    pix1_q <= pix;
    first1_q <= first_now;
    rbin1_q <= bin;
  end

  bin_req_t req;
  logic [8:0] sumv, diffv;
  assign sumv  = 9'(hist_rd_q) + 9'(pix1_q);
  assign diffv = first1_q ? 9'(pix1_q) + 9'd255 - 9'(hist_rd_q)
                          : 9'(hist_rd_q) + 9'd255 - 9'(pix1_q);
  assign req.bump = p1_q && pair1_q;
  assign req.sum_bin = sumv;
  assign req.diff_bin = diffv;

  logic clr_now, rd_now;
  logic [CntW-1:0] sum_c, diff_c;
  assign clr_now = in_acc && kind == KIND_CLEAR;
  assign rd_now  = in_acc && kind == KIND_READ;

  sdh_bins u_bins (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req),
    .rd_i     (rd_now),
    .rd_bin_i (bin),
    .clr_i    (clr_now),
    .busy_o   (busy),
    .sum_o    (sum_c),
    .diff_o   (diff_c)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q <= 5'd1;
      dir_q <= DIR_0;
      width_q <= 11'd1024;
      height_q <= 11'd1024;
      col_q <= '0;
      row_q <= '0;
      hp_q <= '0;
      pairs_q <= '0;
      p1_q <= 1'b0;
      pair1_q <= 1'b0;
      rd1_q <= 1'b0;
      outv_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_DIST:   dist_q <= cfg_data_i[4:0];
          REG_DIR:    dir_q <= cfg_data_i[1:0];
          REG_WIDTH:  width_q <= cfg_data_i;
          default:    height_q <= cfg_data_i;
        endcase
      end
      p1_q <= take_pix;
      pair1_q <= pair_now;
      rd1_q <= rd_now;
      if (clr_now) begin
        col_q <= '0;
        row_q <= '0;
        hp_q <= '0;
        pairs_q <= '0;
      end else if (take_pix) begin
        if (pair_now && pairs_q != CntMax) pairs_q <= pairs_q + 1'b1;
        hp_q <= (32'(hp_q) == HistDepth - 1) ? '0 : hp_q + 1'b1;
        if (col_q + 1'b1 >= wl) begin
          col_q <= '0;
          row_q <= (row_q + 1'b1 >= hl) ? '0 : row_q + 1'b1;
        end else begin
          col_q <= col_q + 1'b1;
        end
      end
      // pairs_q is final when the read is sampled: no pixel in flight
      if (rd1_q) outv_q <= 1'b1;
      else if (m_axis_tready) outv_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd1_q) outd_q <= {pairs_q, diff_c, sum_c, rbin1_q};
  end

  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = outd_q;

  `SDH_ASSERT(a_rd_out, clk_i, rst_ni, rd1_q |=> m_axis_tvalid)
  `SDH_ASSERT(a_no_in_busy, clk_i, rst_ni, busy |-> !s_axis_tready)
  `SDH_ASSERT(a_one_flight, clk_i, rst_ni, rd1_q |-> !p1_q)
endmodule
